[src/per_type_second_byte_budget_top_macros.svh]
// Assertion macros for the per-type byte budget policer.
// Used by per_type_second_byte_budget_top; expects clk and rst_n in scope.
`ifndef PER_TYPE_SECOND_BYTE_BUDGET_TOP_MACROS_SVH
`define PER_TYPE_SECOND_BYTE_BUDGET_TOP_MACROS_SVH

// same-cycle implication
`define PTSBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTSBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ptsbb_pkg.sv]
// Package for the per-type byte budget policer: types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package ptsbb_pkg;

  localparam int NUM_TYPES_DEF = 256;
  localparam int CNT_W   = 32;
  localparam int SEC_W   = 32;
  localparam int BYTES_W = 17;
  localparam int LEN_W   = 16;
  localparam int TYPE_W  = 8;
  localparam int CFG_W   = 16;

  localparam logic [BYTES_W-1:0] HEADER_COST    = 17'd13;
  localparam logic [15:0]        BYTE_LIMIT_RST = 16'd2048;
  localparam logic [7:0]         MAX_TYPE_RST   = 8'd255;
  localparam logic [CNT_W-1:0]   CNT_SAT        = '1;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    CFG_BYTE_LIMIT = 1'b0,
    CFG_MAX_TYPE   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } clr_state_t;

  typedef struct packed {
    logic busy;
    logic we;
  } clr_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [SEC_W-1:0]   cur_sec;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   msg_total;
    logic [CNT_W-1:0]   sec_total;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             admitted;
    logic             type_seen;
    logic [CNT_W-1:0] admitted_count;
    logic [CNT_W-1:0] seconds_count;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

endpackage

[src/ptsbb_if.sv]
// Valid/ready channel interfaces for items into and results out of the policer.
// Depends on ptsbb_pkg.
`timescale 1ns / 1ps
interface ptsbb_in_if
  import ptsbb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [TYPE_W-1:0]   msg_type;
  logic [SEC_W-1:0]    second_stamp;
  logic [LEN_W-1:0]    payload_length;

  modport source (output valid, opcode, msg_type, second_stamp, payload_length,
                  input ready);
  modport sink   (input valid, opcode, msg_type, second_stamp, payload_length,
                  output ready);
endinterface

interface ptsbb_out_if
  import ptsbb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             admitted;
  logic             type_seen;
  logic [CNT_W-1:0] admitted_count;
  logic [CNT_W-1:0] seconds_count;

  modport source (output valid, admitted, type_seen, admitted_count, seconds_count,
                  input ready);
  modport sink   (input valid, admitted, type_seen, admitted_count, seconds_count,
                  output ready);
endinterface

[src/per_type_second_byte_budget_top.sv]
// Per-message-type byte budget policer, top level.
// Depends on ptsbb_pkg, ptsbb_if, ptsbb_ram, ptsbb_clr, ptsbb_upd and the macros header.
`timescale 1ns / 1ps
// Each item is read from the per-type table on acceptance and its entry is
// written back as its result moves into the output register, when stage 1
// advances; a forward register covers an item that follows at once on the same
// type, so the block takes one item per cycle while its result is not held back.
// A result held back by the sink stalls the input. After reset a clearing pass
// over all NUM_TYPES entries marks every entry unused; no item is taken
// meanwhile, while configuration writes are taken at any time.
`include "per_type_second_byte_budget_top_macros.svh"
module per_type_second_byte_budget_top
  import ptsbb_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ptsbb_in_if.sink          in_ch,
  ptsbb_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(NUM_TYPES);

  logic [15:0] byte_limit_r;
  logic [7:0]  max_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= BYTE_LIMIT_RST;
      max_type_r   <= MAX_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BYTE_LIMIT: byte_limit_r <= cfg_data;
        CFG_MAX_TYPE:   max_type_r   <= cfg_data[7:0];
        default:        byte_limit_r <= byte_limit_r;
      endcase
    end
  end

  clr_ctl_t         clr;
  logic [IDX_W-1:0] clr_addr;

  ptsbb_clr #(.NUM_TYPES(NUM_TYPES)) u_clr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (clr),
    .addr  (clr_addr)
  );

  logic               in_acc;
  logic               s1_vld_r;
  logic               s1_adv;
  op_t                s1_op_r;
  logic               s1_tbl_r;
  logic [TYPE_W-1:0]  s1_type_r;
  logic [SEC_W-1:0]   s1_sec_r;
  logic [LEN_W-1:0]   s1_len_r;
  logic [IDX_W-1:0]   s1_addr;
  logic               out_vld_r;
  res_t               out_res_r;
  logic               fwd_vld_r;
  logic [IDX_W-1:0]   fwd_addr_r;
  entry_t             fwd_data_r;
  entry_t             ram_rdata;
  entry_t             old_ent;
  entry_t             new_ent;
  res_t               upd_res;
  logic               upd_we;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !clr.busy && (!s1_vld_r || s1_adv);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_addr      = IDX_W'(s1_type_r);

  assign ram_we    = clr.we || (s1_adv && upd_we);
  assign ram_waddr = clr.we ? clr_addr : s1_addr;
  assign ram_wdata = clr.we ? entry_t'('0) : new_ent;

  ptsbb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TYPES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (IDX_W'(in_ch.msg_type)),
    .rdata (ram_rdata)
  );

  assign old_ent = (fwd_vld_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : ram_rdata;

  ptsbb_upd u_upd (
    .op             (s1_op_r),
    .in_table       (s1_tbl_r),
    .msg_type       (s1_type_r),
    .second_stamp   (s1_sec_r),
    .payload_length (s1_len_r),
    .byte_limit     (byte_limit_r),
    .max_type_id    (max_type_r),
    .old_ent        (old_ent),
    .new_ent        (new_ent),
    .we             (upd_we),
    .res            (upd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (clr.we) begin
        fwd_vld_r <= 1'b0;
      end else if (s1_adv && upd_we) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_ch.opcode);
      s1_tbl_r  <= 32'(in_ch.msg_type) < NUM_TYPES;
      s1_type_r <= in_ch.msg_type;
      s1_sec_r  <= in_ch.second_stamp;
      s1_len_r  <= in_ch.payload_length;
    end
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
    if (s1_adv && upd_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= new_ent;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.admitted       = out_res_r.admitted;
  assign out_ch.type_seen      = out_res_r.type_seen;
  assign out_ch.admitted_count = out_res_r.admitted_count;
  assign out_ch.seconds_count  = out_res_r.seconds_count;

  logic out_live;
  logic s1_query;
  logic clr_quiet;
  logic fwd_load;

  assign out_live  = out_ch.type_seen && (out_ch.admitted_count != '0) &&
                     (out_ch.seconds_count != '0);
  assign s1_query  = s1_vld_r && (s1_op_r == OP_QUERY) && !clr.busy;
  assign clr_quiet = !s1_vld_r && !out_vld_r && !in_ch.ready;
  assign fwd_load  = s1_adv && upd_we && !clr.we;

  `PTSBB_ASSERT_IMP(a_admit_seen, out_ch.valid && out_ch.admitted, out_live, "admit, no entry")
  `PTSBB_ASSERT_IMP(a_query_nowr, s1_query, !ram_we, "query wrote the table")
  `PTSBB_ASSERT_IMP(a_clr_idle, clr.busy, clr_quiet, "item in flight during clearing")
  `PTSBB_ASSERT_NXT(a_fwd_track, fwd_load, fwd_vld_r && fwd_data_r.valid, "forward write lost")

endmodule

[src/ptsbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ptsbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ptsbb_clr.sv]
// Post-reset clearing sequencer: sweeps every table entry to invalid.
// Depends on ptsbb_pkg.
`timescale 1ns / 1ps
module ptsbb_clr
  import ptsbb_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  localparam int IDX_W = $clog2(NUM_TYPES)
) (
  input  logic             clk,
  input  logic             rst_n,
  output clr_ctl_t         ctl,
  output logic [IDX_W-1:0] addr
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_TYPES - 1);

  clr_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl     = '0;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        ctl.busy = 1'b1;
        ctl.we   = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_RUN: begin
        ctl = '0;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign addr = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/ptsbb_upd.sv]
// Budget check and entry update for one item, plus its result.
// Depends on ptsbb_pkg.
`timescale 1ns / 1ps
module ptsbb_upd
  import ptsbb_pkg::*;
(
  input  op_t               op,
  input  logic              in_table,
  input  logic [TYPE_W-1:0] msg_type,
  input  logic [SEC_W-1:0]  second_stamp,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [15:0]       byte_limit,
  input  logic [7:0]        max_type_id,
  input  entry_t            old_ent,
  output entry_t            new_ent,
  output logic              we,
  output res_t              res
);

  logic [BYTES_W-1:0] cost;
  logic [BYTES_W:0]   sum;
  logic               offer_ok;
  logic               fits;
  logic               same;

  assign cost     = HEADER_COST + BYTES_W'(payload_length);
  assign sum      = {1'b0, old_ent.bytes} + {1'b0, cost};
  assign offer_ok = (op == OP_OFFER) && in_table && (msg_type <= max_type_id);
  assign fits     = cost <= BYTES_W'(byte_limit);
  assign same     = old_ent.valid && (old_ent.cur_sec == second_stamp);

  always_comb begin
    new_ent = old_ent;
    we      = 1'b0;
    if (offer_ok && fits) begin
      if (!same) begin
        new_ent.valid     = 1'b1;
        new_ent.cur_sec   = second_stamp;
        new_ent.bytes     = cost;
        new_ent.msg_total = old_ent.valid ? sat_inc(old_ent.msg_total) : CNT_W'(1);
        new_ent.sec_total = old_ent.valid ? sat_inc(old_ent.sec_total) : CNT_W'(1);
        we                = 1'b1;
      end else if (sum <= (BYTES_W + 1)'(byte_limit)) begin
        new_ent.bytes     = sum[BYTES_W-1:0];
        new_ent.msg_total = sat_inc(old_ent.msg_total);
        we                = 1'b1;
      end
    end
  end

  always_comb begin
    res.admitted       = we;
    res.type_seen      = in_table && new_ent.valid;
    res.admitted_count = res.type_seen ? new_ent.msg_total : '0;
    res.seconds_count  = res.type_seen ? new_ent.sec_total : '0;
  end

endmodule

[bench/testbench.sv]
// Testbench for per_type_second_byte_budget_top: per-type byte budget admission policer.
// Directed table then random phases; results are checked against the table's expected values or an in-bench predictor.
// Depends on ptsbb_pkg, ptsbb_if and the policer RTL.
`timescale 1ns / 1ps
module testbench;
  import ptsbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 225;

  typedef struct packed {
    logic        cfg_do;
    logic [15:0] lim;
    logic [7:0]  top;
    op_t         op;
    logic [7:0]  msg_type;
    logic [31:0] sec;
    logic [15:0] len;
    logic        known;
    res_t        exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ptsbb_in_if  in_ch ();
  ptsbb_out_if out_ch ();

  per_type_second_byte_budget_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and configuration copy
  logic [15:0] lim_bytes;
  logic [7:0]  top_type;
  logic        live      [NUM_TYPES_DEF];
  logic [31:0] open_sec  [NUM_TYPES_DEF];
  logic [17:0] spent     [NUM_TYPES_DEF];
  logic [31:0] msg_tally [NUM_TYPES_DEF];
  logic [31:0] sec_tally [NUM_TYPES_DEF];

  logic [31:0] stamp_of [NUM_TYPES_DEF];
  res_t pending_results [$];
  stim_row_t dir_rows [24];

  int mismatches = 0;
  int quiet = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic res_t budget_step(input op_t op, input logic [7:0] t,
                                       input logic [31:0] sec, input logic [15:0] len);
    res_t r;
    logic [17:0] cost;
    r = '0;
    cost = 18'(HEADER_COST) + 18'(len);
    if (op == OP_OFFER && t <= top_type && cost <= 18'(lim_bytes)) begin
      if (!live[t] || open_sec[t] != sec) begin
        sec_tally[t] = live[t] ? sat_up(sec_tally[t]) : 32'd1;
        msg_tally[t] = live[t] ? sat_up(msg_tally[t]) : 32'd1;
        open_sec[t] = sec;
        spent[t] = cost;
        live[t] = 1'b1;
        r.admitted = 1'b1;
      end else if (spent[t] + cost <= 18'(lim_bytes)) begin
        spent[t] = spent[t] + cost;
        msg_tally[t] = sat_up(msg_tally[t]);
        r.admitted = 1'b1;
      end
    end
    if (live[t]) begin
      r.type_seen = 1'b1;
      r.admitted_count = msg_tally[t];
      r.seconds_count = sec_tally[t];
    end
    return r;
  endfunction

  task automatic send_item(input op_t op, input logic [7:0] t, input logic [31:0] sec,
                           input logic [15:0] len, input logic known, input res_t typed);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.msg_type       <= t;
    in_ch.second_stamp   <= sec;
    in_ch.payload_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = budget_step(op, t, sec, len);
    pending_results.insert(pending_results.size(), known ? typed : predicted);
  endtask

  task automatic send_random(input int unsigned lim);
    int r;
    op_t op;
    logic [7:0] t;
    logic [31:0] sec;
    logic [15:0] len;
    t = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    op = ($urandom_range(0, 99) < 15) ? OP_QUERY : OP_OFFER;
    r = $urandom_range(0, 99);
    if (r < 70) sec = stamp_of[t];
    else if (r < 88) sec = stamp_of[t] + 32'd1;
    else if (r < 95) sec = stamp_of[t] + $urandom_range(2, 1000000);
    else if (r < 98) sec = stamp_of[t] - $urandom_range(1, 50);
    else sec = $urandom;
    if (op == OP_OFFER) stamp_of[t] = sec;
    if ($urandom_range(0, 99) < 85) len = 16'($urandom_range(0, lim / 3));
    else len = 16'($urandom_range(0, 65535));
    send_item(op, t, sec, len, 1'b0, '0);
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] lim, input logic [7:0] top);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BYTE_LIMIT;
    cfg_data  <= lim;
    @(negedge clk);
    cfg_index <= CFG_MAX_TYPE;
    cfg_data  <= {8'h00, top};
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_bytes = lim;
    top_type = top;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (out_ch.admitted !== e.admitted) begin
          $error("admitted: expected %0d, got %0d", e.admitted, out_ch.admitted);
          mismatches++;
        end
        if (out_ch.type_seen !== e.type_seen) begin
          $error("type_seen: expected %0d, got %0d", e.type_seen, out_ch.type_seen);
          mismatches++;
        end
        if (out_ch.admitted_count !== e.admitted_count) begin
          $error("admitted_count: expected %0d, got %0d", e.admitted_count,
                 out_ch.admitted_count);
          mismatches++;
        end
        if (out_ch.seconds_count !== e.seconds_count) begin
          $error("seconds_count: expected %0d, got %0d", e.seconds_count,
                 out_ch.seconds_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result sink; hold_left forces a long back-pressure stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned phase_lim [PHASES];
    logic [7:0]  phase_top [PHASES];
    phase_lim = '{2048, 400, 65535, 100, 5000, 1000};
    phase_top = '{8'd255, 8'd63, 8'd255, 8'd255, 8'd255, 8'd200};

    dir_rows = '{
      '{1'b0, 16'd0, 8'd0, OP_QUERY, 8'h00, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h0, 16'd0, 1'b1, '{1'b1, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h0, 16'd2035, 1'b1,
        '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h0, 16'd2022, 1'b1,
        '{1'b1, 1'b1, 32'd2, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd2, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h1, 16'd2035, 1'b1,
        '{1'b1, 1'b1, 32'd3, 32'd2}},
      // earlier second opens a new budget
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h0, 16'd0, 1'b1, '{1'b1, 1'b1, 32'd4, 32'd3}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'hFF, 32'hFFFF_FFFF, 16'd0, 1'b1,
        '{1'b1, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_QUERY, 8'hFF, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h01, 32'hAAAA_AAAA, 16'hAAAA, 1'b1,
        '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'hAA, 32'h5555_5555, 16'h0555, 1'b0, '0},
      // type above max_type_id
      '{1'b1, 16'hFFFF, 8'd127, OP_OFFER, 8'h80, 32'h3, 16'd0, 1'b1,
        '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h7F, 32'h3, 16'd65522, 1'b1,
        '{1'b1, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h7F, 32'h3, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_QUERY, 8'hAA, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'hAA, 32'h5555_5555, 16'd0, 1'b1,
        '{1'b0, 1'b1, 32'd1, 32'd1}},
      // cost above limit on a new second
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h1, 16'hFFFF, 1'b1,
        '{1'b0, 1'b1, 32'd4, 32'd3}},
      '{1'b1, 16'd0, 8'd0, OP_OFFER, 8'h00, 32'h1, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd4, 32'd3}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h01, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{1'b0, 16'd0, 8'd0, OP_QUERY, 8'h00, 32'h0, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd4, 32'd3}},
      '{1'b1, 16'd13, 8'd255, OP_OFFER, 8'h02, 32'h7, 16'd0, 1'b1,
        '{1'b1, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h02, 32'h7, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{1'b0, 16'd0, 8'd0, OP_OFFER, 8'h02, 32'h8, 16'd0, 1'b0, '0}
    };

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BYTE_LIMIT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_OFFER;
    in_ch.msg_type = '0;
    in_ch.second_stamp = '0;
    in_ch.payload_length = '0;
    lim_bytes = BYTE_LIMIT_RST;
    top_type = MAX_TYPE_RST;
    for (int i = 0; i < NUM_TYPES_DEF; i++) begin
      live[i] = 1'b0;
      stamp_of[i] = $urandom;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_do) begin
        drain();
        write_limits(dir_rows[i].lim, dir_rows[i].top);
      end
      send_item(dir_rows[i].op, dir_rows[i].msg_type, dir_rows[i].sec, dir_rows[i].len,
                dir_rows[i].known, dir_rows[i].exp);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_limits(16'(phase_lim[p]), phase_top[p]);
      send_idle_pct = (p < 2) ? 24 : (p < 4) ? 76 : 0;
      recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 24 : 0;
      if (p == 4) hold_left = 300;
      repeat (PHASE_ITEMS) send_random(phase_lim[p]);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
